// ===== sv/cpf_pkg.sv =====
// Shared constants, field widths and codes for the clip playback mixer.
`timescale 1ns / 1ps
package cpf_pkg;

	localparam int CFG_W    = 32;
	localparam int IDX_W    = 4;
	localparam int TPOS_W   = 32;
	localparam int ADDR_W   = 16;
	localparam int CLEN_W   = 24;
	localparam int FLEN_W   = 23;
	localparam int GAIN_W   = 16;
	localparam int LSTART_W = 16;
	localparam int LLEN_W   = 17;
	localparam int DL_W     = 17;
	localparam int POS_W    = 17;
	localparam int Q_W      = 15;
	localparam int MULT_W   = 16;
	localparam int SCALE_SHIFT = 27;

	localparam logic [MULT_W-1:0] FADE_UNITY = 16'h8000;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_PLAY = 1'b1
	} cmd_t;

	typedef enum logic [IDX_W-1:0] {
		REG_START_SAMPLE = 4'd0,
		REG_CLIP_LENGTH  = 4'd1,
		REG_FADE_IN_LEN  = 4'd2,
		REG_FADE_OUT_LEN = 4'd3,
		REG_GAIN         = 4'd4,
		REG_LOOP_ENABLE  = 4'd5,
		REG_LOOP_START   = 4'd6,
		REG_LOOP_LEN     = 4'd7
	} cfg_reg_t;

endpackage

// ===== sv/cpf_if.sv =====
// Valid/ready channel interfaces for the item and result words.
`timescale 1ns / 1ps
interface cpf_item_if #(parameter int SAMPLE_BITS = 24);
	import cpf_pkg::*;
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic                          channel;
	logic        [ADDR_W-1:0]      load_address;
	logic signed [SAMPLE_BITS-1:0] load_sample;
	logic        [TPOS_W-1:0]      timeline_pos;
	logic                          playing;
	logic signed [SAMPLE_BITS-1:0] mix_in;

	modport source(output valid, cmd, channel, load_address, load_sample, timeline_pos,
		playing, mix_in, input ready);
	modport sink(input valid, cmd, channel, load_address, load_sample, timeline_pos,
		playing, mix_in, output ready);
endinterface

interface cpf_result_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] mix_out;
	logic                          contributed;

	modport source(output valid, mix_out, contributed, input ready);
	modport sink(input valid, mix_out, contributed, output ready);
endinterface

// ===== sv/cpf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module cpf_div #(
	parameter int RW = 17,
	parameter int NB = 24
) (
	input  logic          clk,
	input  logic          en,
	input  logic [RW-1:0] rem_init,
	input  logic [NB-1:0] num,
	input  logic [RW-1:0] den,
	output logic [NB-1:0] quot,
	output logic [RW-1:0] rem
);
	logic [RW-1:0] rem_s [NB];
	logic [NB-1:0] quo_s [NB];
	logic [NB-1:0] num_s [NB];
	logic [RW-1:0] den_s [NB];

	logic [RW-1:0] r_in [NB];
	logic [NB-1:0] q_in [NB];
	logic [NB-1:0] n_in [NB];
	logic [RW-1:0] d_in [NB];

	assign r_in[0] = rem_init;
	assign q_in[0] = '0;
	assign n_in[0] = num;
	assign d_in[0] = den;

	for (genvar k = 1; k < NB; k++) begin : g_link
		assign r_in[k] = rem_s[k-1];
		assign q_in[k] = quo_s[k-1];
		assign n_in[k] = num_s[k-1];
		assign d_in[k] = den_s[k-1];
	end

	for (genvar k = 0; k < NB; k++) begin : g_step
		logic [RW:0] trial;
		logic        ge;
		// shift in the next dividend bit, subtract when it fits
		assign trial = {r_in[k], n_in[k][NB-1]};
		assign ge    = trial >= {1'b0, d_in[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? RW'(trial - {1'b0, d_in[k]}) : trial[RW-1:0];
				quo_s[k] <= {q_in[k][NB-2:0], ge};
				num_s[k] <= n_in[k] << 1;
				den_s[k] <= d_in[k];
			end
		end
	end

	assign quot = quo_s[NB-1];
	assign rem  = rem_s[NB-1];
endmodule

// ===== sv/cpf_delay.sv =====
// Enabled delay line that keeps item words aligned with the datapath.
`timescale 1ns / 1ps
module cpf_delay #(
	parameter int W = 8,
	parameter int N = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] line_s [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) line_s[i] <= '0;
		end else if (en) begin
			line_s[0] <= d;
			for (int i = 1; i < N; i++) line_s[i] <= line_s[i-1];
		end
	end

	assign q = line_s[N-1];
endmodule

// ===== sv/clip_playback_fade_loop_mixer.sv =====
// Top level: clip sampler voice with loop wrap, linear fades, gain and mix.
`timescale 1ns / 1ps
// Path: a play result passes stage 1, the offset divider, stage 26, the fade dividers and
//   stages 42 to 45; a load word writes clip memory from stage 26 and gives no result.
// Throughput: one word per cycle, set by the fully pipelined 24-stage offset divider and
//   the two 15-stage fade dividers; the whole pipe holds only while a result is refused.
// Reset: arst_n clears configuration to its defaults, the data length and all valids;
//   clip memory is not cleared and holds garbage until loaded.
module clip_playback_fade_loop_mixer #(
	parameter int CLIP_DEPTH  = 65536,
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	cpf_item_if.sink                  item,
	cpf_result_if.source              result,
	input  logic                      cfg_we,
	input  logic [cpf_pkg::IDX_W-1:0] cfg_index,
	input  logic [cpf_pkg::CFG_W-1:0] cfg_wdata
);
	import cpf_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int MW = $clog2(CHANNELS * CLIP_DEPTH);
	localparam int PW = SB + 33;   // sample times gain-fade product
	localparam int SW = PW + 1;    // sum with mix

	// ---------------- configuration ----------------
	logic [TPOS_W-1:0]   start_q;
	logic [CLEN_W-1:0]   clen_q;
	logic [FLEN_W-1:0]   fin_len_q;
	logic [FLEN_W-1:0]   fout_len_q;
	logic [GAIN_W-1:0]   gain_q;
	logic                loop_en_q;
	logic [LSTART_W-1:0] lstart_q;
	logic [LLEN_W-1:0]   llen_q;
	logic [DL_W-1:0]     dl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= '0;
			clen_q     <= '0;
			fin_len_q  <= '0;
			fout_len_q <= '0;
			gain_q     <= GAIN_RESET;
			loop_en_q  <= 1'b0;
			lstart_q   <= '0;
			llen_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_START_SAMPLE: start_q    <= cfg_wdata[TPOS_W-1:0];
				REG_CLIP_LENGTH:  clen_q     <= cfg_wdata[CLEN_W-1:0];
				REG_FADE_IN_LEN:  fin_len_q  <= cfg_wdata[FLEN_W-1:0];
				REG_FADE_OUT_LEN: fout_len_q <= cfg_wdata[FLEN_W-1:0];
				REG_GAIN:         gain_q     <= cfg_wdata[GAIN_W-1:0];
				REG_LOOP_ENABLE:  loop_en_q  <= cfg_wdata[0];
				REG_LOOP_START:   lstart_q   <= cfg_wdata[LSTART_W-1:0];
				REG_LOOP_LEN:     llen_q     <= cfg_wdata[LLEN_W-1:0];
				default: ;  // unknown index: drop the write
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	// The whole pipe advances together; hold only when the output word is refused.
	logic out_v_q;
	logic adv;
	logic accept;

	assign adv        = !out_v_q || result.ready;
	assign item.ready = adv;
	assign accept     = item.valid && adv;

	// ---------------- entry checks ----------------
	logic              ch_ok_c;
	logic              load_ok_c;
	logic [TPOS_W-1:0] offset_c;
	logic              early_pass_c;

	assign ch_ok_c   = 32'(item.channel) < CHANNELS;
	assign load_ok_c = ch_ok_c && (32'(item.load_address) < CLIP_DEPTH);
	assign offset_c  = item.timeline_pos - start_q;
	assign early_pass_c = !item.playing || (gain_q == '0) || (clen_q == '0) || (dl_q == '0)
		|| !ch_ok_c || (item.timeline_pos < start_q) || (offset_c >= TPOS_W'(clen_q));

	// Data length follows the most recent in-range load, in item order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dl_q <= '0;
		end else if (accept && (cmd_t'(item.cmd) == CMD_LOAD) && load_ok_c) begin
			dl_q <= {1'b0, item.load_address} + DL_W'(1);
		end
	end

	// ---------------- stage 1: registered item ----------------
	logic              v_s1, play_s1, pass_s1, ch_s1, lok_s1;
	logic signed [SB-1:0] mix_s1, lsamp_s1;
	logic [ADDR_W-1:0] laddr_s1;
	logic [CLEN_W-1:0] off_s1;
	logic [DL_W-1:0]   dl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			play_s1  <= cmd_t'(item.cmd) == CMD_PLAY;
			pass_s1  <= early_pass_c;
			ch_s1    <= item.channel;
			lok_s1   <= load_ok_c;
			mix_s1   <= item.mix_in;
			lsamp_s1 <= item.load_sample;
			laddr_s1 <= item.load_address;
			off_s1   <= offset_c[CLEN_W-1:0];
			dl_s1    <= dl_q;
		end
	end

	// ---------------- offset wrap: remainder by loop or data length ----------------
	logic [DL_W-1:0] mod_den_s1;
	logic [DL_W-1:0] rem_s25;

	assign mod_den_s1 = (llen_q != '0) ? llen_q : dl_s1;

	cpf_div #(.RW(DL_W), .NB(CLEN_W)) u_wrap_div (
		.clk      (clk),
		.en       (adv),
		.rem_init ('0),
		.num      (off_s1),
		.den      (mod_den_s1),
		.quot     (),
		.rem      (rem_s25)
	);

	localparam int WA = 6 + 2 * SB + ADDR_W + CLEN_W + DL_W;
	logic [WA-1:0] side_a_d, side_a_q;
	logic              v_s25, play_s25, pass_s25, ch_s25, lok_s25;
	logic signed [SB-1:0] mix_s25, lsamp_s25;
	logic [ADDR_W-1:0] laddr_s25;
	logic [CLEN_W-1:0] off_s25;
	logic [DL_W-1:0]   dl_s25;

	assign side_a_d = {v_s1, play_s1, pass_s1, ch_s1, lok_s1, 1'b0, mix_s1, lsamp_s1,
		laddr_s1, off_s1, dl_s1};

	cpf_delay #(.W(WA), .N(CLEN_W)) u_side_a (
		.clk (clk), .arst_n (arst_n), .en (adv), .d (side_a_d), .q (side_a_q)
	);

	logic spare_a;
	assign {v_s25, play_s25, pass_s25, ch_s25, lok_s25, spare_a, mix_s25, lsamp_s25,
		laddr_s25, off_s25, dl_s25} = side_a_q;

	// ---------------- stage 26: final position and fade windows ----------------
	logic             wrap_c;
	logic [POS_W-1:0] pos_c;
	logic signed [CLEN_W:0] fstart_c;
	logic             fin_c, fout_c, fozero_c;
	logic [CLEN_W-1:0] fonum_c;

	assign wrap_c = loop_en_q && (off_s25 >= CLEN_W'(dl_s25));
	always_comb begin
		pos_c = off_s25[POS_W-1:0];
		if (wrap_c) begin
			pos_c = (llen_q != '0) ? POS_W'(lstart_q) + rem_s25 : rem_s25;
		end
	end

	assign fstart_c = $signed({1'b0, clen_q}) - $signed({2'b0, fout_len_q});
	assign fin_c    = (fin_len_q != '0) && (FLEN_W'(pos_c) < fin_len_q);
	assign fout_c   = (fout_len_q != '0)
		&& ($signed({{(CLEN_W + 1 - POS_W){1'b0}}, pos_c}) > fstart_c);
	assign fozero_c = CLEN_W'(pos_c) >= clen_q;
	assign fonum_c  = clen_q - CLEN_W'(pos_c);

	logic              v_s26, play_s26, pass_s26, ch_s26, lok_s26;
	logic              fin_s26, fout_s26, fozero_s26;
	logic signed [SB-1:0] mix_s26, lsamp_s26;
	logic [ADDR_W-1:0] laddr_s26;
	logic [POS_W-1:0]  pos_s26;
	logic [FLEN_W-1:0] fonum_s26;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s26 <= 1'b0;
		end else if (adv) begin
			v_s26 <= v_s25;
		end
	end

	// Without a wrap, test the full offset against the data length.
	always_ff @(posedge clk) begin
		if (adv) begin
			play_s26   <= play_s25;
			pass_s26   <= pass_s25 || (wrap_c ? (pos_c >= dl_s25)
				: (off_s25 >= CLEN_W'(dl_s25)));
			ch_s26     <= ch_s25;
			lok_s26    <= lok_s25;
			fin_s26    <= fin_c;
			fout_s26   <= fout_c;
			fozero_s26 <= fozero_c;
			mix_s26    <= mix_s25;
			lsamp_s26  <= lsamp_s25;
			laddr_s26  <= laddr_s25;
			pos_s26    <= pos_c;
			fonum_s26  <= fonum_c[FLEN_W-1:0];
		end
	end

	// ---------------- clip memory ----------------
	// Loads write at the same stage where plays read, so order is kept without forwarding.
	logic signed [SB-1:0] clip_mem [CHANNELS * CLIP_DEPTH];
	logic signed [SB-1:0] rd_s27;
	logic [MW-1:0]        wr_idx, rd_idx;

	assign wr_idx = MW'(ch_s26) * MW'(CLIP_DEPTH) + MW'(laddr_s26);
	assign rd_idx = MW'(ch_s26) * MW'(CLIP_DEPTH) + MW'(pos_s26);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (v_s26 && !play_s26 && lok_s26) clip_mem[wr_idx] <= lsamp_s26;
			rd_s27 <= clip_mem[rd_idx];
		end
	end

	// ---------------- fade dividers ----------------
	logic [Q_W-1:0] fi_s41, fo_s41;

	cpf_div #(.RW(FLEN_W), .NB(Q_W)) u_fin_div (
		.clk      (clk),
		.en       (adv),
		.rem_init (FLEN_W'(pos_s26)),
		.num      ('0),
		.den      (fin_len_q),
		.quot     (fi_s41),
		.rem      ()
	);

	cpf_div #(.RW(FLEN_W), .NB(Q_W)) u_fout_div (
		.clk      (clk),
		.en       (adv),
		.rem_init (fonum_s26),
		.num      ('0),
		.den      (fout_len_q),
		.quot     (fo_s41),
		.rem      ()
	);

	localparam int WB = 6 + SB;
	logic [WB-1:0] side_b_q;
	logic          v_s41, play_s41, pass_s41, fin_s41, fout_s41, fozero_s41;
	logic signed [SB-1:0] mix_s41, samp_s41;

	cpf_delay #(.W(WB), .N(Q_W)) u_side_b (
		.clk (clk), .arst_n (arst_n), .en (adv),
		.d   ({v_s26, play_s26, pass_s26, fin_s26, fout_s26, fozero_s26, mix_s26}),
		.q   (side_b_q)
	);
	assign {v_s41, play_s41, pass_s41, fin_s41, fout_s41, fozero_s41, mix_s41} = side_b_q;

	cpf_delay #(.W(SB), .N(Q_W - 1)) u_samp_dly (
		.clk (clk), .arst_n (arst_n), .en (adv), .d (rd_s27), .q (samp_s41)
	);

	// ---------------- stage 42: combined fade multiplier ----------------
	logic [MULT_W-1:0]         mi_c;
	logic [Q_W-1:0]            fov_c;
	logic [MULT_W+Q_W-1:0]     mprod_c;
	logic [MULT_W-1:0]         m_c;

	assign mi_c    = fin_s41 ? {1'b0, fi_s41} : FADE_UNITY;
	assign fov_c   = fozero_s41 ? '0 : fo_s41;
	assign mprod_c = mi_c * fov_c;
	assign m_c     = fout_s41 ? MULT_W'(mprod_c >> Q_W) : mi_c;

	logic              v_s42, play_s42, pass_s42;
	logic signed [SB-1:0] mix_s42, samp_s42;
	logic [MULT_W-1:0] m_s42;

	// ---------------- stage 43: gain times fade ----------------
	logic              v_s43, play_s43, pass_s43;
	logic signed [SB-1:0] mix_s43, samp_s43;
	logic [GAIN_W+MULT_W-1:0] gf_s43;

	// ---------------- stage 44: sample times gain-fade ----------------
	logic              v_s44, play_s44, pass_s44;
	logic signed [SB-1:0] mix_s44;
	logic signed [PW-1:0] prod_s44;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s42 <= 1'b0;
			v_s43 <= 1'b0;
			v_s44 <= 1'b0;
		end else if (adv) begin
			v_s42 <= v_s41;
			v_s43 <= v_s42;
			v_s44 <= v_s43;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			play_s42 <= play_s41;
			pass_s42 <= pass_s41;
			mix_s42  <= mix_s41;
			samp_s42 <= samp_s41;
			m_s42    <= m_c;

			play_s43 <= play_s42;
			pass_s43 <= pass_s42;
			mix_s43  <= mix_s42;
			samp_s43 <= samp_s42;
			gf_s43   <= gain_q * m_s42;

			play_s44 <= play_s43;
			pass_s44 <= pass_s43;
			mix_s44  <= mix_s43;
			prod_s44 <= samp_s43 * $signed({1'b0, gf_s43});
		end
	end

	// ---------------- stage 45: scale, mix, saturate ----------------
	logic signed [PW-1:0] scaled_c;
	logic signed [SW-1:0] sum_c, max_c, min_c, sat_c;

	assign scaled_c = prod_s44 >>> SCALE_SHIFT;  // floor toward minus infinity
	assign sum_c    = SW'(scaled_c) + SW'(mix_s44);
	assign max_c    = {{(SW - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
	assign min_c    = ~max_c;

	always_comb begin
		sat_c = sum_c;
		if (sum_c > max_c) sat_c = max_c;
		if (sum_c < min_c) sat_c = min_c;
	end

	logic signed [SB-1:0] mix_out_q;
	logic                 contrib_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s44 && play_s44;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mix_out_q <= pass_s44 ? mix_s44 : sat_c[SB-1:0];
			contrib_q <= !pass_s44;
		end
	end

	assign result.valid       = out_v_q;
	assign result.mix_out     = mix_out_q;
	assign result.contributed = contrib_q;

	// ---------------- assertions ----------------
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !result.ready |=> out_v_q && $stable(mix_out_q) && $stable(contrib_q))
		else $error("output word changed while refused");

	a_fade_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s42 && play_s42 |-> m_s42 <= FADE_UNITY)
		else $error("fade multiplier above unity");

	a_dl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(dl_q) <= CLIP_DEPTH)
		else $error("data length beyond clip depth");

	a_no_accept_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !result.ready |-> !accept ##1 $stable(v_s44))
		else $error("pipeline moved during stall");
endmodule

// ===== sim/clip_playback_fade_loop_mixer_tb.sv =====
// Self-checking testbench for the clip playback mixer: loads, plays, config sweeps.
`timescale 1ns / 1ps
module clip_playback_fade_loop_mixer_tb;
	import cpf_pkg::*;

	localparam int IDLE_LIMIT = 5000;  // cycles with no word moving on either side
	localparam int DRAIN_CYCLES = 60;  // covers the play path and the load path
	localparam int PHASES = 12;

	typedef struct {
		cmd_t               cmd;
		bit                 channel;
		logic [15:0]        addr;
		logic signed [23:0] smp;
		logic [31:0]        tpos;
		bit                 playing;
		logic signed [23:0] mix;
	} word_t;

	typedef struct {
		logic signed [23:0] mix;
		bit                 contrib;
	} mix_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	cpf_item_if #(24) item_ch();
	cpf_result_if #(24) result_ch();

	clip_playback_fade_loop_mixer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Current register values, shared by the word generator and the mix predictor.
	// Writes only happen when the block is idle, so both see the same settings.
	bit [31:0] start_sample;
	bit [23:0] clip_len;
	bit [22:0] fade_in;
	bit [22:0] fade_out;
	bit [15:0] gain;
	bit        loop_en;
	bit [15:0] loop_start;
	bit [16:0] loop_len;

	// Predictor state: clip memory as seen at word acceptance.
	logic signed [23:0] clip_mem [2][65536];
	int pred_dl;

	// Generator shadow: which entries will have been written, and the data length then.
	bit gen_wr [2][65536];
	int gen_dl;

	word_t word_q[$];
	mix_t  mix_q[$];
	int errors;
	int n_results;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Map a play word to the clip memory position it reads, or -1 for pass-through.
	function automatic longint clip_pos(bit [31:0] tpos, bit playing, int dl);
		longint off;
		longint p;
		if (!playing || gain == 0 || clip_len == 0 || dl == 0)
			return -1;
		if (tpos < start_sample)
			return -1;
		off = longint'(tpos - start_sample);
		if (off >= clip_len)
			return -1;
		p = off;
		if (loop_en && p >= dl) begin
			if (loop_len > 0)
				p = loop_start + p % loop_len;
			else
				p = p % dl;
		end
		if (p >= dl)
			return -1;
		return p;
	endfunction

	// Q1.15 combined fade multiplier at position p.
	function automatic longint fade_mult(longint p);
		longint m;
		longint fo;
		m = 32768;
		if (fade_in > 0 && p < fade_in)
			m = (p << 15) / fade_in;
		if (fade_out > 0 && p > longint'(clip_len) - longint'(fade_out)) begin
			fo = (p < clip_len) ? ((longint'(clip_len) - p) << 15) / fade_out : 0;
			m = (m * fo) >> 15;
		end
		return m;
	endfunction

	// Update clip memory for a load, or queue the expected mix for a play.
	function automatic void apply_word(word_t w);
		longint p;
		longint prod;
		longint sum;
		mix_t e;
		if (w.cmd == CMD_LOAD) begin
			clip_mem[w.channel][w.addr] = w.smp;
			pred_dl = int'(w.addr) + 1;
			return;
		end
		e.mix = w.mix;
		e.contrib = 1'b0;
		p = clip_pos(w.tpos, w.playing, pred_dl);
		if (p >= 0) begin
			prod = longint'(clip_mem[w.channel][p]) * longint'(gain) * fade_mult(p);
			sum = longint'(w.mix) + (prod >>> SCALE_SHIFT);  // floor division
			if (sum > 8388607)
				sum = 8388607;
			if (sum < -8388608)
				sum = -8388608;
			e.mix = sum[23:0];
			e.contrib = 1'b1;
		end
		mix_q.push_back(e);
	endfunction

	task automatic add_load(bit ch, bit [15:0] addr, bit [23:0] smp);
		word_t w;
		w = '{CMD_LOAD, ch, addr, smp, $urandom, $urandom_range(0, 1), $urandom};
		gen_wr[ch][addr] = 1'b1;
		gen_dl = int'(addr) + 1;
		word_q.push_back(w);
	endtask

	// Steer around reads of never-written entries: flip channel, else stop transport.
	task automatic add_play(bit ch, bit [31:0] tpos, bit playing, bit [23:0] mix);
		word_t w;
		longint p;
		p = clip_pos(tpos, playing, gen_dl);
		if (p >= 0 && !gen_wr[ch][p]) begin
			ch = ~ch;
			if (!gen_wr[ch][p])
				playing = 1'b0;
		end
		w = '{CMD_PLAY, ch, $urandom, $urandom, tpos, playing, mix};
		word_q.push_back(w);
	endtask

	task automatic write_reg(cfg_reg_t r, bit [31:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		case (r)
			REG_START_SAMPLE: start_sample = v;
			REG_CLIP_LENGTH:  clip_len = v[23:0];
			REG_FADE_IN_LEN:  fade_in = v[22:0];
			REG_FADE_OUT_LEN: fade_out = v[22:0];
			REG_GAIN:         gain = v[15:0];
			REG_LOOP_ENABLE:  loop_en = v[0];
			REG_LOOP_START:   loop_start = v[15:0];
			REG_LOOP_LEN:     loop_len = v[16:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_all(bit [31:0] ss, bit [23:0] cl, bit [22:0] fi, bit [22:0] fo,
			bit [15:0] g, bit le, bit [15:0] ls, bit [16:0] ll);
		write_reg(REG_START_SAMPLE, ss);
		write_reg(REG_CLIP_LENGTH, cl);
		write_reg(REG_FADE_IN_LEN, fi);
		write_reg(REG_FADE_OUT_LEN, fo);
		write_reg(REG_GAIN, g);
		write_reg(REG_LOOP_ENABLE, le);
		write_reg(REG_LOOP_START, ls);
		write_reg(REG_LOOP_LEN, ll);
	endtask

	// Hold until every queued word is taken and every mix has come back, then let
	// in-flight loads land before anything touches the registers.
	task automatic drain();
		while (word_q.size() > 0 || mix_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One random play word with the offset weighted toward the loaded data.
	task automatic rand_play();
		int r;
		bit [31:0] off;
		bit [23:0] mix;
		r = $urandom_range(0, 9);
		if (r < 6)
			off = $urandom_range(0, gen_dl + 5);
		else if (r < 8)
			off = $urandom_range(0, (clip_len > 3000) ? 3000 : clip_len + 10);
		else
			off = $urandom;
		mix = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000)
			: $urandom;
		if (r == 9)
			add_play($urandom_range(0, 1), start_sample - $urandom_range(1, 50), 1'b1, mix);
		else
			add_play($urandom_range(0, 1), start_sample + off, $urandom_range(0, 15) != 0,
				mix);
	endtask

	task automatic rand_load();
		int r;
		bit [23:0] smp;
		r = $urandom_range(0, 19);
		smp = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000)
			: $urandom;
		if (r == 0) begin
			// Far address touches the high bits; pull the data length back right after.
			add_load($urandom_range(0, 1), $urandom, smp);
			add_load($urandom_range(0, 1), $urandom_range(0, 150), $urandom);
		end else begin
			add_load($urandom_range(0, 1), $urandom_range(0, 300), smp);
		end
	endtask

	// Stimulus: fill, directed corners, extremes and mute, then random phases each with fresh settings.
	initial begin
		bit [31:0] ss;
		errors = 0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		start_sample = 0;
		clip_len = 0;
		fade_in = 0;
		fade_out = 0;
		gain = GAIN_RESET;
		loop_en = 0;
		loop_start = 0;
		loop_len = 0;
		pred_dl = 0;
		gen_dl = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Play at reset defaults: clip length zero passes everything through.
		add_play(1'b0, 32'd5, 1'b1, 24'h123456);
		for (int a = 0; a < 100; a++) begin
			add_load(1'b0, a, $urandom);
			add_load(1'b1, a, $urandom);
		end
		drain();

		// Directed corners: fade edges, stopped, before start, past clip, saturation.
		set_all(32'd100, 24'd300, 23'd50, 23'd70, 16'd40960, 1'b1, 16'd10, 17'd20);
		add_load(1'b0, 16'd0, 24'h7FFFFF);
		add_load(1'b1, 16'd1, 24'h800000);
		add_load(1'b0, 16'd99, 24'h7FFFFF);
		add_play(1'b0, 32'd100, 1'b1, 24'h000000);  // fade-in at zero
		add_play(1'b1, 32'd101, 1'b1, 24'h800000);  // negative floor, saturate low
		add_play(1'b0, 32'd149, 1'b1, 24'h7FFFFF);  // last fade-in step
		add_play(1'b0, 32'd150, 1'b1, 24'h000001);  // unity
		add_play(1'b0, 32'd199, 1'b1, 24'h000000);  // end of loaded data
		add_play(1'b0, 32'd200, 1'b1, 24'h000000);  // loop wrap
		add_play(1'b1, 32'd399, 1'b1, 24'h000000);  // last clip sample, loop wrap into fade-in
		add_play(1'b0, 32'd400, 1'b1, 24'h7FFFFF);  // past clip
		add_play(1'b0, 32'd99, 1'b1, 24'h800000);   // before start
		add_play(1'b1, 32'd150, 1'b0, 24'h5A5A5A);  // stopped
		add_play(1'b0, 32'hFFFFFFFF, 1'b1, 24'h000000);
		drain();

		// Extremes, then mute and zero-length loop over whole data.
		set_all(32'hFFFFFFFF, 24'hFFFFFF, 23'h7FFFFF, 23'h7FFFFF, 16'd40960, 1'b1,
			16'hFFFF, 17'h10000);
		for (int i = 0; i < 20; i++)
			add_play($urandom_range(0, 1), 32'hFFFFFFFF + $urandom_range(0, 120), 1'b1,
				$urandom);
		drain();
		set_all(32'd0, 24'd1000, 23'd0, 23'd0, 16'd0, 1'b1, 16'd0, 17'd0);
		for (int i = 0; i < 10; i++)
			rand_play();
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			ss = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000);
			set_all(ss, ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(1, 2000),
				$urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 600),
				$urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 600),
				$urandom_range(0, 40960), $urandom_range(0, 1), $urandom_range(0, 300),
				$urandom_range(0, 300));
			for (int i = 0; i < 80; i++) begin
				if ($urandom_range(0, 3) == 0)
					rand_load();
				else
					rand_play();
			end
			drain();
		end

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Driver: bursts of words separated by random gaps; hold a word until taken.
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.cmd <= CMD_LOAD;
			item_ch.channel <= 1'b0;
			item_ch.load_address <= '0;
			item_ch.load_sample <= '0;
			item_ch.timeline_pos <= '0;
			item_ch.playing <= 1'b0;
			item_ch.mix_in <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!(item_ch.valid && !item_ch.ready)) begin
			if (item_ch.valid && item_ch.ready) begin
				apply_word(word_q.pop_front());
			end
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				item_ch.valid <= 1'b0;
			end else if (word_q.size() > 0) begin
				item_ch.valid <= 1'b1;
				item_ch.cmd <= word_q[0].cmd;
				item_ch.channel <= word_q[0].channel;
				item_ch.load_address <= word_q[0].addr;
				item_ch.load_sample <= word_q[0].smp;
				item_ch.timeline_pos <= word_q[0].tpos;
				item_ch.playing <= word_q[0].playing;
				item_ch.mix_in <= word_q[0].mix;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor: check each mix word against the oldest expectation; stall on a
	// rotating pattern, plus one long hold-off while words are still waiting to go in,
	// so the pipe backs up into the input.
	int stall_left;
	bit long_done;
	int cyc;
	always @(posedge clk or negedge arst_n) begin
		mix_t e;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left <= 0;
			long_done <= 1'b0;
			cyc <= 0;
			n_results <= 0;
		end else begin
			cyc <= cyc + 1;
			if (result_ch.valid && result_ch.ready) begin
				n_results <= n_results + 1;
				if (mix_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected word mix_out=%0d contributed=%0b", $realtime,
						result_ch.mix_out, result_ch.contributed);
				end else begin
					e = mix_q.pop_front();
					if (result_ch.mix_out !== e.mix) begin
						errors++;
						$display("%0t: mix_out expected %0d actual %0d", $realtime, e.mix,
							result_ch.mix_out);
					end
					if (result_ch.contributed !== e.contrib) begin
						errors++;
						$display("%0t: contributed expected %0b actual %0b", $realtime,
							e.contrib, result_ch.contributed);
					end
				end
			end
			if (!long_done && n_results >= 300 && word_q.size() >= 10) begin
				long_done <= 1'b1;
				stall_left <= 400;
				result_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				result_ch.ready <= 1'b0;
			end else begin
				case ((cyc >> 8) % 3)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= $urandom_range(0, 1);
					default: result_ch.ready <= $urandom_range(0, 3) != 0;
				endcase
			end
		end
	end

	// Watchdog: end the run if no word moves on either side for too long.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule
